// File: rtl/tfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_pkg
// shared types and codes of the timestamped feature store
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int FeatW  = 32;
  localparam int ValW   = 64;
  localparam int StampW = 64;
  localparam int CfgIdxW = 8;

  typedef enum logic [0:0] {
    CMD_SET = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEFAULT_ENABLE = 8'd0,
    REG_DEFAULT_VALUE  = 8'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [FeatW-1:0]  feature;
    logic [ValW-1:0]   value;
    logic [StampW-1:0] timestep;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic            used_default;
    status_t         status;
  } out_item_t;

  // search query held for the whole scan
  typedef struct packed {
    cmd_t              cmd;
    logic [FeatW-1:0]  feature;
    logic [StampW-1:0] timestep;
  } query_t;

  // running best handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              have;
    logic [StampW-1:0] key;
    logic [ValW-1:0]   val;
  } carry_t;

  // slot write
  typedef struct packed {
    logic              en;
    logic [FeatW-1:0]  feature;
    logic [ValW-1:0]   value;
    logic [StampW-1:0] stamp;
  } slot_wr_t;

endpackage

// File: rtl/tfs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_cell
// one store slot plus one stage of the search chain
// ----------------------------------------------------------------------------
module tfs_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  tfs_pkg::query_t q,
  input  logic [CW-1:0]   count,
  input  tfs_pkg::slot_wr_t wr,
  input  logic [IW-1:0]   wr_idx,
  input  tfs_pkg::carry_t carry_in,
  input  logic [IW-1:0]   idx_in,
  output tfs_pkg::carry_t carry_out,
  output logic [IW-1:0]   idx_out
);
  import tfs_pkg::*;

  logic [FeatW-1:0]  feat;
  logic [ValW-1:0]   val;
  logic [StampW-1:0] stamp;

  logic              live;
  logic              hit;
  logic              better;
  logic [StampW-1:0] key_new;
  carry_t            carry_next;
  logic [IW-1:0]     idx_next;

  assign live = count > CW'(IDX);

  always_comb begin
    key_new = q.timestep - stamp;
    hit     = 1'b0;
    better  = 1'b0;
    case (q.cmd)
      CMD_SET: begin
        key_new = stamp;
        hit     = live && (feat == q.feature);
        better  = !carry_in.have || (stamp < carry_in.key);
      end
      CMD_GET: begin
        hit    = live && (feat == q.feature) && (stamp < q.timestep);
        better = !carry_in.have || (key_new < carry_in.key);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    carry_next = carry_in;
    idx_next   = idx_in;
    if (carry_in.active && hit && better) begin
      carry_next.have = 1'b1;
      carry_next.key  = key_new;
      carry_next.val  = val;
      idx_next        = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IW'(IDX))) begin
      feat  <= wr.feature;
      val   <= wr.value;
      stamp <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.active <= 1'b0;
    end else begin
      carry_out.active <= carry_next.active;
    end
    carry_out.have <= carry_next.have;
    carry_out.key  <= carry_next.key;
    carry_out.val  <= carry_next.val;
    idx_out        <= idx_next;
  end

endmodule

// File: rtl/timestamped_feature_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_feature_store_top
// fixed-capacity store of (feature, value, timestep) entries with set and get
// ----------------------------------------------------------------------------
//
//  channel | signals                              | item
//  --------+--------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data          | set or get request
//  out     | out_valid, out_ready, out_data       | one result per request
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
//  a set into a store with room writes the next free slot
//  a get, or a set into a full store, walks a token through the chain of
//  CAPACITY cells, one cell per cycle
//  reset clears the fill count, the registers and the chain tokens; slot
//  contents are left as they are and are never read before written
//  a stalled output holds the finished item; the next item is taken once the
//  result has moved into the output register
//
module timestamped_feature_store_top #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tfs_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tfs_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tfs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                  cfg_data
);
  import tfs_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // configuration registers
  logic            default_enable;
  logic [ValW-1:0] default_value;

  // control
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic          start;
  logic          start_go;
  logic          append;
  logic          finish;
  logic          load_out;

  query_t          q;
  logic [ValW-1:0] q_value;
  out_item_t       res;
  out_item_t       res_next;

  slot_wr_t      wr;
  logic [IW-1:0] wr_idx;

  // chain links: link[i] feeds cell i, link[CAPACITY] is the chain output
  carry_t        link [CAPACITY+1];
  logic [IW-1:0] link_idx [CAPACITY+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_enable <= 1'b0;
      default_value  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEFAULT_ENABLE: default_enable <= cfg_data[0];
        REG_DEFAULT_VALUE:  default_value  <= cfg_data;
        default:            ;
      endcase
    end
  end

  // token entering the first cell
  assign link[0].active = start;
  assign link[0].have   = 1'b0;
  assign link[0].key    = '0;
  assign link[0].val    = '0;
  assign link_idx[0]    = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tfs_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .q         (q),
      .count     (count),
      .wr        (wr),
      .wr_idx    (wr_idx),
      .carry_in  (link[i]),
      .idx_in    (link_idx[i]),
      .carry_out (link[i+1]),
      .idx_out   (link_idx[i+1])
    );
  end

  assign finish = (state == S_SCAN) && link[CAPACITY].active;

  // next state, slot write and finished result
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    start_go   = 1'b0;
    append     = 1'b0;
    load_out   = 1'b0;
    wr         = '0;
    wr_idx     = '0;
    res_next   = res;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((in_data.cmd == CMD_SET) && (count < CW'(CAPACITY))) begin
            // room left: write the next free slot
            append              = 1'b1;
            wr.en               = 1'b1;
            wr.feature          = in_data.feature;
            wr.value            = in_data.value;
            wr.stamp            = in_data.timestep;
            wr_idx              = count[IW-1:0];
            res_next.read_value = '0;
            res_next.used_default = 1'b0;
            res_next.status     = ST_OK;
            state_next          = S_OUT;
          end else begin
            start_go   = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_OUT;
          if (q.cmd == CMD_SET) begin
            res_next.read_value   = '0;
            res_next.used_default = 1'b0;
            if (link[CAPACITY].have) begin
              // overwrite the oldest slot of this feature
              wr.en           = 1'b1;
              wr.feature      = q.feature;
              wr.value        = q_value;
              wr.stamp        = q.timestep;
              wr_idx          = link_idx[CAPACITY];
              res_next.status = ST_OK;
            end else begin
              res_next.status = ST_NO_SLOT;
            end
          end else if (link[CAPACITY].have) begin
            res_next.read_value   = link[CAPACITY].val;
            res_next.used_default = 1'b0;
            res_next.status       = ST_OK;
          end else if (default_enable) begin
            res_next.read_value   = default_value;
            res_next.used_default = 1'b1;
            res_next.status       = ST_OK;
          end else begin
            res_next.read_value   = '0;
            res_next.used_default = 1'b0;
            res_next.status       = ST_NOT_FOUND;
          end
        end
      end
      S_OUT: begin
        // hand over once the output register is free
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= start_go;
      if (append) begin
        count <= count + CW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q.cmd      <= in_data.cmd;
      q.feature  <= in_data.feature;
      q.timestep <= in_data.timestep;
      q_value    <= in_data.value;
    end
    res <= res_next;
    if (load_out) begin
      out_data <= res;
    end
  end

  // the fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // the chain token only comes out while a scan is pending
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    link[CAPACITY].active |-> state == S_SCAN)
    else $error("chain token outside of a scan");

  // a scan ends once its token has passed every cell of the chain
  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(CAPACITY) link[CAPACITY].active)
    else $error("chain token lost");

  // a default value is only reported with an ok status
  a_default_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.used_default |-> out_data.status == ST_OK)
    else $error("default value with error status");

endmodule

// File: tb/sv/timestamped_feature_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_feature_store_checker
// watches the request, result and register channels of the feature store,
// keeps a shadow copy of the slots and registers, and compares every result
// in order against the value that the shadow store gives
// ----------------------------------------------------------------------------
module timestamped_feature_store_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  tfs_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  tfs_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tfs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                  cfg_data,
  output int                           mismatches,
  output int                           outstanding
);
  import tfs_pkg::*;

  logic              default_en;
  logic [ValW-1:0]   default_val;
  int                fill;
  logic [FeatW-1:0]  slot_feature [CAPACITY];
  logic [ValW-1:0]   slot_value   [CAPACITY];
  logic [StampW-1:0] slot_stamp   [CAPACITY];
  out_item_t         pending_results [$];
  int                errors = 0;

  // apply one request to the shadow store and return its result
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t         res;
    int                pick;
    logic [StampW-1:0] best_dist;
    logic [StampW-1:0] delta;
    res = '0;
    res.status = ST_OK;
    pick = -1;
    best_dist = '0;
    if (req.cmd == CMD_SET) begin
      if (fill < CAPACITY) begin
        slot_feature[fill] = req.feature;
        slot_value[fill] = req.value;
        slot_stamp[fill] = req.timestep;
        fill++;
      end else begin
        // oldest slot of the same feature, lowest slot on a tie
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_feature[i] == req.feature &&
              (pick < 0 || slot_stamp[i] < slot_stamp[pick])) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          res.status = ST_NO_SLOT;
        end else begin
          slot_value[pick] = req.value;
          slot_stamp[pick] = req.timestep;
        end
      end
    end else begin
      // closest strictly earlier stamp, lowest slot on a tie
      for (int i = 0; i < fill; i++) begin
        if (slot_feature[i] == req.feature && slot_stamp[i] < req.timestep) begin
          delta = req.timestep - slot_stamp[i];
          if (pick < 0 || delta < best_dist) begin
            pick = i;
            best_dist = delta;
          end
        end
      end
      if (pick >= 0) begin
        res.read_value = slot_value[pick];
      end else if (default_en) begin
        res.read_value = default_val;
        res.used_default = 1'b1;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    return res;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      default_en = 1'b0;
      default_val = '0;
      fill = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with none pending: value %h default %b status %0d",
                                 out_data.read_value, out_data.used_default,
                                 out_data.status));
        end else begin
          want = pending_results.pop_front();
          if (out_data.read_value !== want.read_value ||
              out_data.used_default !== want.used_default ||
              out_data.status !== want.status) begin
            note_failure($sformatf({"result differs: want value %h default %b status %0d,",
                                    " got value %h default %b status %0d"},
                                   want.read_value, want.used_default, want.status,
                                   out_data.read_value, out_data.used_default,
                                   out_data.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(serve_request(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEFAULT_ENABLE: begin
            default_en = cfg_data[0];
          end
          REG_DEFAULT_VALUE: begin
            default_val = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    mismatches <= errors;
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/sv/tb_timestamped_feature_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_feature_store_top
// drives set and get items and register writes into the feature store with
// random gaps on both sides; a checker beside the block predicts every result
// and this module reports the verdict
// ----------------------------------------------------------------------------
module tb_timestamped_feature_store_top;
  import tfs_pkg::*;

  localparam int Capacity     = 16;
  localparam int PhaseCount   = 5;
  localparam int PhaseItems   = 260;
  // enough for one get walking the whole chain plus the output stage
  localparam int SettleCycles = 3 * (Capacity + 2);

  // register indexes past the end of the list, writes there are dropped
  localparam logic [CfgIdxW-1:0] RegIdxUnused = 8'd2;
  localparam logic [CfgIdxW-1:0] RegIdxLast   = '1;

  localparam logic [FeatW-1:0] FeatLow  = '0;
  localparam logic [FeatW-1:0] FeatHigh = '1;
  localparam logic [FeatW-1:0] FeatTie  = 32'd3;
  localparam logic [FeatW-1:0] FeatMiss = 32'h1234_5678;
  localparam logic [FeatW-1:0] FeatPeek = 32'd7;
  // features that stay in the store once it is full
  localparam logic [FeatW-1:0] KnownFeatures [7] = '{
    32'd0, 32'hFFFF_FFFF, 32'd3, 32'd8, 32'd9, 32'd10, 32'd11
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  int mismatches;
  int outstanding;

  // when set, that side runs without gaps until it flips back
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  timestamped_feature_store_top #(
    .CAPACITY (Capacity)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  timestamped_feature_store_checker #(
    .CAPACITY (Capacity)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // result side: stall for a gap from draw_gap before taking each item
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
    end
  end

  function automatic in_item_t request(cmd_t cmd, logic [FeatW-1:0] feat,
                                       logic [ValW-1:0] val, logic [StampW-1:0] ts);
    in_item_t req;
    req.cmd = cmd;
    req.feature = feat;
    req.value = val;
    req.timestep = ts;
    return req;
  endfunction

  // mostly known features and a narrow band of stamps so that lookups hit,
  // replacements land and ties happen; the rest is wide noise
  function automatic in_item_t random_request();
    in_item_t req;
    int       roll;
    req.cmd = $urandom_range(0, 1) ? CMD_GET : CMD_SET;
    roll = $urandom_range(0, 99);
    req.feature = (roll < 85) ? KnownFeatures[$urandom_range(0, 6)] : $urandom;
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      req.value = '0;
    end else if (roll == 1) begin
      req.value = '1;
    end else begin
      req.value = {$urandom, $urandom};
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      req.timestep = 64'($urandom_range(0, 40));
    end else if (roll < 75) begin
      req.timestep = '1 - 64'($urandom_range(0, 3));
    end else if (roll < 85) begin
      req.timestep = {32'hFFFF_FFFF, $urandom};
    end else begin
      req.timestep = {$urandom, $urandom};
    end
    return req;
  endfunction

  // leaves in_valid high; wait_idle lowers it, the next call only before a gap
  task automatic send_request(input in_item_t req);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!(in_valid && in_ready));
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // only called with the block idle; optionally pokes the unused indexes
  task automatic configure(input bit enable, input logic [63:0] dflt, input bit poke_unused);
    write_reg(REG_DEFAULT_VALUE, dflt);
    write_reg(REG_DEFAULT_ENABLE, 64'(enable));
    if (poke_unused) begin
      write_reg(RegIdxUnused, {$urandom, $urandom});
      write_reg(RegIdxLast, '1);
    end
    cfg_valid <= 1'b0;
  endtask

  // every item gives one result, so an empty expectation queue means idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [ValW-1:0] tie_first;
    logic [ValW-1:0] tie_second;
    logic [ValW-1:0] newest;
    logic [ValW-1:0] dflt;
    bit              enable;

    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----

    // empty store with the default on: stamp zero and the top stamp both miss
    configure(1'b1, '1, 1'b1);
    send_request(request(CMD_GET, FeatPeek, '0, '0));
    send_request(request(CMD_GET, FeatPeek, '1, '1));
    wait_idle();

    // default off from here until the random phases
    configure(1'b0, '1, 1'b0);
    send_request(request(CMD_GET, FeatPeek, '1, 64'd5));

    // fill the store: extremes first, then three entries of one feature
    // where two share the same stamp
    tie_first = {$urandom, $urandom};
    tie_second = {$urandom, $urandom};
    newest = {$urandom, $urandom};
    send_request(request(CMD_SET, FeatLow, '0, '0));
    send_request(request(CMD_SET, FeatHigh, '1, '1));
    send_request(request(CMD_SET, FeatTie, tie_first, 64'd10));
    send_request(request(CMD_SET, FeatTie, tie_second, 64'd10));
    send_request(request(CMD_SET, FeatTie, newest, 64'd20));
    for (int i = 5; i < Capacity; i++) begin
      send_request(request(CMD_SET, KnownFeatures[3 + $urandom_range(0, 3)],
                           {$urandom, $urandom}, 64'($urandom_range(1, 40))));
    end

    // equal distance on the tied pair, lowest slot wins
    send_request(request(CMD_GET, FeatTie, '0, 64'd15));
    // stamp zero can never find an earlier entry
    send_request(request(CMD_GET, FeatLow, '0, '0));
    // stored stamp equal to the bound is not earlier
    send_request(request(CMD_GET, FeatHigh, '0, '1));
    // widest possible distance
    send_request(request(CMD_GET, FeatLow, '1, '1));
    // full store, feature absent: nothing to replace
    send_request(request(CMD_SET, FeatMiss, {$urandom, $urandom}, 64'd50));
    // full store, oldest stamps tied: lowest of the pair is overwritten
    send_request(request(CMD_SET, FeatTie, {$urandom, $urandom}, 64'd30));
    send_request(request(CMD_GET, FeatTie, '0, 64'd25));

    // ---- random part, one register setting per phase ----
    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      case (p)
        0: begin
          enable = 1'b0;
          dflt = {$urandom, $urandom};
        end
        1: begin
          enable = 1'b1;
          dflt = '1;
        end
        2: begin
          enable = 1'b1;
          dflt = '0;
        end
        3: begin
          enable = 1'b0;
          dflt = '1;
        end
        default: begin
          enable = 1'b1;
          dflt = {$urandom, $urandom};
        end
      endcase
      configure(enable, dflt, p == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        send_request(random_request());
      end
    end

    // drain, then watch a while longer for stray results
    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
